FILE: design/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the texture sampler RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: design/bts_pkg.sv
// ---------------------------------------------------------------------------
// bts_pkg
// Types, constants and helpers shared by the bilinear texture sampler.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bts_pkg;

    localparam int ADDR_W          = 16;
    localparam int STORE_DEPTH     = 65536;
    localparam int CH_W            = 8;
    localparam int TEXEL_W         = 3 * CH_W;
    localparam int COORD_W         = 16;
    localparam int FRAC_W          = 15;
    localparam int SIZE_REG_W      = 9;
    localparam int CFG_IDX_W       = 8;
    localparam int DEF_MAX_WIDTH   = 256;
    localparam int DEF_MAX_HEIGHT  = 256;
    localparam int DEF_WEIGHT_BITS = 8;
    localparam int QUEUE_DEPTH     = 8;
    localparam int OUT_DEPTH       = 4;

    localparam logic [COORD_W-1:0]    COORD_ONE    = 16'h8000;
    localparam logic [SIZE_REG_W-1:0] SIZE_RESET   = 9'd256;

    localparam logic [CFG_IDX_W-1:0] REG_TEX_WIDTH  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TEX_HEIGHT = 8'd1;

    typedef enum logic {
        KIND_WRITE  = 1'b0,
        KIND_SAMPLE = 1'b1
    } kind_t;

    function automatic int cmd_width(input int wb);
        return 1 + 4 * ADDR_W + TEXEL_W + 2 * wb;
    endfunction

endpackage

`default_nettype wire

FILE: design/bts_in_if.sv
// ---------------------------------------------------------------------------
// bts_in_if
// Input channel: texel writes and sample requests.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bts_in_if;
    import bts_pkg::*;

    logic                valid;
    logic                ready;
    logic                kind;
    logic [ADDR_W-1:0]   texel_addr;
    logic [CH_W-1:0]     texel_red;
    logic [CH_W-1:0]     texel_green;
    logic [CH_W-1:0]     texel_blue;
    logic [COORD_W-1:0]  coord_u;
    logic [COORD_W-1:0]  coord_v;

    modport source (
        output valid, kind, texel_addr, texel_red, texel_green, texel_blue,
               coord_u, coord_v,
        input  ready
    );
    modport sink (
        input  valid, kind, texel_addr, texel_red, texel_green, texel_blue,
               coord_u, coord_v,
        output ready
    );
endinterface

`default_nettype wire

FILE: design/bts_out_if.sv
// ---------------------------------------------------------------------------
// bts_out_if
// Output channel: filtered RGB colour.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bts_out_if;
    import bts_pkg::*;

    logic            valid;
    logic            ready;
    logic [CH_W-1:0] out_red;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_blue;

    modport source (output valid, out_red, out_green, out_blue, input ready);
    modport sink   (input valid, out_red, out_green, out_blue, output ready);
endinterface

`default_nettype wire

FILE: design/bts_cfg_if.sv
// ---------------------------------------------------------------------------
// bts_cfg_if
// Configuration write channel: register index and data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bts_cfg_if;
    import bts_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [SIZE_REG_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: design/bts_ram.sv
// ---------------------------------------------------------------------------
// bts_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bts_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

`default_nettype wire

FILE: design/bts_fifo.sv
// ---------------------------------------------------------------------------
// bts_fifo
// Small register FIFO with power-of-two depth and show-ahead read.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module bts_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] pop_data,
    output logic                  not_empty
);
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        count_next  = count_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    `ASSERT_ALWAYS(a_no_overflow, clk, rst_n, !(push && full), "fifo push while full")
    `ASSERT_ALWAYS(a_no_underflow, clk, rst_n, !(pop && !not_empty), "fifo pop while empty")
    `ASSERT_IMPLIES(a_count_hold, clk, rst_n, !push && !pop, ##1 $stable(count_reg), "count moved")
endmodule

`default_nettype wire

FILE: design/bts_front.sv
// ---------------------------------------------------------------------------
// bts_front
// Accepts transactions, scales coordinates and forms the texel addresses.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bts_front #(
    parameter int MAX_WIDTH   = 256,
    parameter int MAX_HEIGHT  = 256,
    parameter int WEIGHT_BITS = 8
) (
    input  wire logic                                      clk,
    input  wire logic                                      rst_n,
    bts_in_if.sink                                         in_ch,
    input  wire logic [$clog2(MAX_WIDTH+1)-1:0]            wdt,
    input  wire logic [$clog2(MAX_HEIGHT+1)-1:0]           hgt,
    output logic                                           cmd_push,
    output logic [bts_pkg::cmd_width(WEIGHT_BITS)-1:0]     cmd_data,
    input  wire logic                                      cmd_pop
);
    import bts_pkg::*;

    localparam int EW  = $clog2(MAX_WIDTH);
    localparam int EH  = $clog2(MAX_HEIGHT);
    localparam int EWS = $clog2(MAX_WIDTH + 1);
    localparam int PWU = COORD_W + EW;
    localparam int PWV = COORD_W + EH;
    localparam int RW  = EH + EWS;
    localparam int WB  = WEIGHT_BITS;
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    logic [QCW-1:0]     credit_reg, credit_next;
    logic               accept;

    logic               v1_reg;
    logic               kind1_reg;
    logic [ADDR_W-1:0]  addr1_reg;
    logic [TEXEL_W-1:0] texel1_reg;
    logic [PWU-1:0]     pu1_reg;
    logic [PWV-1:0]     pv1_reg;

    logic [COORD_W-1:0] cu, cv;
    logic [EW-1:0]      wm1;
    logic [EH-1:0]      hm1;

    logic [EW-1:0]      x0, x1;
    logic [EH-1:0]      y0, y1;
    logic [FRAC_W-1:0]  fu, fv;
    logic [RW-1:0]      rp0, rp1;

    logic               v2_reg;
    logic               kind2_reg;
    logic [ADDR_W-1:0]  addr2_reg;
    logic [TEXEL_W-1:0] texel2_reg;
    logic [EW-1:0]      x0_reg, x1_reg;
    logic [ADDR_W-1:0]  r0_reg, r1_reg;
    logic [WB-1:0]      s_reg, t_reg;

    logic [ADDR_W-1:0]  a0, a1, a2, a3;

    assign accept       = in_ch.valid && in_ch.ready;
    assign in_ch.ready  = (credit_reg < QCW'(QUEUE_DEPTH));
    assign credit_next  = credit_reg + QCW'(accept) - QCW'(cmd_pop);

    always_comb
    begin
        cu  = (in_ch.coord_u > COORD_ONE) ? COORD_ONE : in_ch.coord_u;
        cv  = (in_ch.coord_v > COORD_ONE) ? COORD_ONE : in_ch.coord_v;
        wm1 = EW'(wdt - EWS'(1));
        hm1 = EH'(hgt - ($bits(hgt))'(1));
    end

    always_comb
    begin
        x0  = pu1_reg[FRAC_W +: EW];
        y0  = pv1_reg[FRAC_W +: EH];
        fu  = pu1_reg[FRAC_W-1:0];
        fv  = pv1_reg[FRAC_W-1:0];
        x1  = x0 + EW'(fu != '0);
        y1  = y0 + EH'(fv != '0);
        rp0 = RW'(y0) * RW'(wdt);
        rp1 = RW'(y1) * RW'(wdt);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            credit_reg <= '0;
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
        end
        else
        begin
            credit_reg <= credit_next;
            v1_reg     <= accept;
            v2_reg     <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        kind1_reg  <= in_ch.kind;
        addr1_reg  <= in_ch.texel_addr;
        texel1_reg <= {in_ch.texel_red, in_ch.texel_green, in_ch.texel_blue};
        pu1_reg    <= PWU'(cu) * PWU'(wm1);
        pv1_reg    <= PWV'(cv) * PWV'(hm1);

        kind2_reg  <= kind1_reg;
        addr2_reg  <= addr1_reg;
        texel2_reg <= texel1_reg;
        x0_reg     <= x0;
        x1_reg     <= x1;
        r0_reg     <= ADDR_W'(rp0);
        r1_reg     <= ADDR_W'(rp1);
        s_reg      <= fu[FRAC_W-1 -: WB];
        t_reg      <= fv[FRAC_W-1 -: WB];
    end

    always_comb
    begin
        a0 = r0_reg + ADDR_W'(x0_reg);
        a1 = r0_reg + ADDR_W'(x1_reg);
        a2 = r1_reg + ADDR_W'(x0_reg);
        a3 = r1_reg + ADDR_W'(x1_reg);
        if (kind2_reg == KIND_WRITE)
        begin
            a0 = addr2_reg;
        end
    end

    assign cmd_push = v2_reg;
    assign cmd_data = {kind2_reg, a0, a1, a2, a3, texel2_reg, s_reg, t_reg};
endmodule

`default_nettype wire

FILE: design/bts_back.sv
// ---------------------------------------------------------------------------
// bts_back
// Issues texel writes and fetches, blends the four texels per channel.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module bts_back #(
    parameter int WEIGHT_BITS = 8
) (
    input  wire logic                                      clk,
    input  wire logic                                      rst_n,
    input  wire logic                                      cmd_valid,
    input  wire logic [bts_pkg::cmd_width(WEIGHT_BITS)-1:0] cmd_data,
    output logic                                           cmd_pop,
    bts_out_if.source                                      out_ch
);
    import bts_pkg::*;

    localparam int WB  = WEIGHT_BITS;
    localparam int WW  = 2 * WB + 1;
    localparam int PRW = WW + CH_W;
    localparam int ACW = WW + CH_W + 2;
    localparam int OCW = $clog2(OUT_DEPTH + 1);
    localparam logic [WB:0]    WONE  = (WB + 1)'(1) << WB;
    localparam logic [ACW-1:0] ROUND = ACW'(1) << (2 * WB - 1);

    logic               h_kind;
    logic [ADDR_W-1:0]  h_a0, h_a1, h_a2, h_a3;
    logic [TEXEL_W-1:0] h_texel;
    logic [WB-1:0]      h_s, h_t;

    logic               we, issue;
    logic [OCW-1:0]     ocnt_reg, ocnt_next;
    logic [WB:0]        sc, tc;

    logic               v1_reg, v2_reg;
    logic [WW-1:0]      wt_reg [4];
    logic [TEXEL_W-1:0] texel [4];
    logic [PRW-1:0]     prod_reg [3][4];
    logic [ACW-1:0]     acc [3];
    logic [TEXEL_W-1:0] o_data, o_head;
    logic               o_full, o_pop, o_nempty;

    assign {h_kind, h_a0, h_a1, h_a2, h_a3, h_texel, h_s, h_t} = cmd_data;

    assign cmd_pop = cmd_valid && ((h_kind == KIND_WRITE) || (ocnt_reg < OCW'(OUT_DEPTH)));
    assign we      = cmd_pop && (h_kind == KIND_WRITE);
    assign issue   = cmd_pop && (h_kind == KIND_SAMPLE);
    assign o_pop   = out_ch.valid && out_ch.ready;
    assign ocnt_next = ocnt_reg + OCW'(issue) - OCW'(o_pop);

    bts_ram #(.WIDTH(TEXEL_W), .DEPTH(STORE_DEPTH)) u_ram_tl (
        .clk(clk), .we(we), .waddr(h_a0), .wdata(h_texel), .raddr(h_a0), .rdata(texel[0])
    );
    bts_ram #(.WIDTH(TEXEL_W), .DEPTH(STORE_DEPTH)) u_ram_tr (
        .clk(clk), .we(we), .waddr(h_a0), .wdata(h_texel), .raddr(h_a1), .rdata(texel[1])
    );
    bts_ram #(.WIDTH(TEXEL_W), .DEPTH(STORE_DEPTH)) u_ram_bl (
        .clk(clk), .we(we), .waddr(h_a0), .wdata(h_texel), .raddr(h_a2), .rdata(texel[2])
    );
    bts_ram #(.WIDTH(TEXEL_W), .DEPTH(STORE_DEPTH)) u_ram_br (
        .clk(clk), .we(we), .waddr(h_a0), .wdata(h_texel), .raddr(h_a3), .rdata(texel[3])
    );

    always_comb
    begin
        sc = WONE - {1'b0, h_s};
        tc = WONE - {1'b0, h_t};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ocnt_reg <= '0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
        end
        else
        begin
            ocnt_reg <= ocnt_next;
            v1_reg   <= issue;
            v2_reg   <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        wt_reg[0] <= WW'(sc) * WW'(tc);
        wt_reg[1] <= WW'(h_s) * WW'(tc);
        wt_reg[2] <= WW'(sc) * WW'(h_t);
        wt_reg[3] <= WW'(h_s) * WW'(h_t);
        for (int c = 0; c < 3; c++)
        begin
            for (int k = 0; k < 4; k++)
            begin
                prod_reg[c][k] <= PRW'(wt_reg[k])
                                * PRW'(texel[k][TEXEL_W-1-CH_W*c -: CH_W]);
            end
        end
    end

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            acc[c] = ACW'(prod_reg[c][0]) + ACW'(prod_reg[c][1])
                   + ACW'(prod_reg[c][2]) + ACW'(prod_reg[c][3]) + ROUND;
        end
        o_data = {acc[0][2*WB +: CH_W], acc[1][2*WB +: CH_W], acc[2][2*WB +: CH_W]};
    end

    bts_fifo #(.WIDTH(TEXEL_W), .DEPTH(OUT_DEPTH)) u_out_fifo (
        .clk(clk), .rst_n(rst_n),
        .push(v2_reg), .push_data(o_data), .full(o_full),
        .pop(o_pop), .pop_data(o_head), .not_empty(o_nempty)
    );

    assign out_ch.valid = o_nempty;
    assign {out_ch.out_red, out_ch.out_green, out_ch.out_blue} = o_head;

    `ASSERT_ALWAYS(a_credit_bound, clk, rst_n, ocnt_reg <= OCW'(OUT_DEPTH), "credit overrun")
    `ASSERT_ALWAYS(a_result_room, clk, rst_n, !(v2_reg && o_full), "result lost")
    `ASSERT_IMPLIES(a_issue_flow, clk, rst_n, issue, ##2 v2_reg, "sample dropped in blend")
endmodule

`default_nettype wire

FILE: design/bilinear_texture_sampler_unit.sv
// ---------------------------------------------------------------------------
// bilinear_texture_sampler_unit
// Bilinear texture sampler over a 64K-entry row-major RGB texel store.
// ---------------------------------------------------------------------------
// Throughput is one transaction per clock, writes and samples alike, while
// the command queue and the output buffer have room. The rate is set by
// the texel store, kept as four copies that are all written together so
// that the four neighbors of a sample are read in the same cycle. The
// texel store has no reset: sample only texels that have been written.
// Write the size registers only while idle.
`timescale 1ns / 1ps
`default_nettype none

module bilinear_texture_sampler_unit #(
    parameter int MAX_WIDTH   = bts_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT  = bts_pkg::DEF_MAX_HEIGHT,
    parameter int WEIGHT_BITS = bts_pkg::DEF_WEIGHT_BITS
) (
    input  wire logic clk,
    input  wire logic rst_n,
    bts_in_if.sink    in_ch,
    bts_out_if.source out_ch,
    bts_cfg_if.sink   cfg
);
    import bts_pkg::*;

    localparam int EWS   = $clog2(MAX_WIDTH + 1);
    localparam int EHS   = $clog2(MAX_HEIGHT + 1);
    localparam int CMD_W = cmd_width(WEIGHT_BITS);

    logic [SIZE_REG_W-1:0] width_reg, height_reg;
    logic [EWS-1:0]        wdt;
    logic [EHS-1:0]        hgt;

    logic                  f_push, q_full, q_pop, q_valid;
    logic [CMD_W-1:0]      f_data, q_data;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= SIZE_RESET;
            height_reg <= SIZE_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_TEX_WIDTH:  width_reg  <= cfg.data;
                REG_TEX_HEIGHT: height_reg <= cfg.data;
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        if (width_reg == '0)
            wdt = EWS'(1);
        else if (32'(width_reg) > MAX_WIDTH)
            wdt = EWS'(MAX_WIDTH);
        else
            wdt = EWS'(width_reg);

        if (height_reg == '0)
            hgt = EHS'(1);
        else if (32'(height_reg) > MAX_HEIGHT)
            hgt = EHS'(MAX_HEIGHT);
        else
            hgt = EHS'(height_reg);
    end

    bts_front #(
        .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .WEIGHT_BITS(WEIGHT_BITS)
    ) u_front (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .wdt(wdt), .hgt(hgt),
        .cmd_push(f_push), .cmd_data(f_data), .cmd_pop(q_pop)
    );

    bts_fifo #(.WIDTH(CMD_W), .DEPTH(QUEUE_DEPTH)) u_cmd_queue (
        .clk(clk), .rst_n(rst_n),
        .push(f_push), .push_data(f_data), .full(q_full),
        .pop(q_pop), .pop_data(q_data), .not_empty(q_valid)
    );

    bts_back #(.WEIGHT_BITS(WEIGHT_BITS)) u_back (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(q_valid), .cmd_data(q_data), .cmd_pop(q_pop),
        .out_ch(out_ch)
    );
endmodule

`default_nettype wire
